### hw/rtl/hcte_pkg.sv
// hcte_pkg: types and constants for the cookie header token extractor
// no dependencies; imported by http_cookie_token_extractor and http_cookie_token_extractor_tb
`default_nettype none

package hcte_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NAME_LEN_W = 5;
    localparam int unsigned CHAR_IDX_W = 6;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3b;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3d;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_SKIP,
        MODE_NAME,
        MODE_VALUE
    } parse_mode_t;

endpackage

`default_nettype wire

### hw/rtl/http_cookie_token_extractor.sv
// http_cookie_token_extractor: parses one cookie header per frame and returns the token
// depends on hcte_pkg; token bytes kept in a two-bank synchronous memory
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata = header_byte, s_tlast = last_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata = token_char, char_index; m_tuser = ok;
//          |     |                    | m_tlast = last_result
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one header byte per cycle when not held off; parse state updates on each byte taken.
// the marked byte starts a result job: TOKEN_LEN results (one per cycle unless the output
// stalls, read from the registered token memory) or a single failure result.
// after a successful header, token bytes of the next one go to the other memory bank
// while its job drains, so only a marked byte arriving during a running job is held off.
// reset clears parsing and job state; memory contents are not reset.
`default_nettype none

module http_cookie_token_extractor #(
    parameter int unsigned TOKEN_LEN  = 32,
    parameter int unsigned HEADER_MAX = 256,
    parameter int unsigned NAME_MAX   = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [hcte_pkg::S_TDATA_W-1:0]       s_tdata,    // [7:0] header_byte
    input  wire                                  s_tlast,    // last_byte
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [hcte_pkg::M_TDATA_W-1:0]       m_tdata,    // [7:0] token_char,
                                                             // [13:8] char_index, [15:14] 0
    output logic                                 m_tuser,    // ok
    output logic                                 m_tlast,    // last_result
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [hcte_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [hcte_pkg::CFG_W-1:0]           cfg_data
);
    import hcte_pkg::*;

    localparam int unsigned IDX_W = (TOKEN_LEN > 1) ? $clog2(TOKEN_LEN) : 1;
    localparam int unsigned VC_W  = $clog2(TOKEN_LEN + 2);
    localparam int unsigned HL_W  = $clog2(HEADER_MAX + 1);
    localparam int unsigned NP_W  = $clog2(NAME_MAX + 2);
    localparam int unsigned MA_W  = $clog2(2 * TOKEN_LEN);
    localparam int unsigned MEM_DEPTH = 2 * TOKEN_LEN;
    localparam int unsigned CMP_W = 6;

    // configuration
    logic [CFG_W-1:0]      name_low_reg;
    logic [CFG_W-1:0]      name_high_reg;
    logic [NAME_LEN_W-1:0] name_len_reg;

    // per-header parse state
    parse_mode_t      mode_reg, mode_next;
    logic [NP_W-1:0]  pos_reg, pos_next;
    logic             match_reg, match_next;
    logic [VC_W-1:0]  vc_reg, vc_next;
    logic             found_reg, found_next;
    logic             failed_reg, failed_next;
    logic [HL_W-1:0]  hlen_reg, hlen_next;
    logic             bank_reg;
    logic             success;

    // token memory
    logic [BYTE_W-1:0] token_mem [MEM_DEPTH];
    logic              wr_en;
    logic [MA_W-1:0]   wr_addr;
    logic [MA_W-1:0]   rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;

    // result job and output pipeline
    logic             job_busy_reg;
    logic             job_ok_reg;
    logic             job_bank_reg;
    logic [IDX_W-1:0] gen_idx_reg;
    logic             issue;
    logic             issue_last;
    logic             s1_valid_reg;
    logic             s1_ok_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_last_reg;
    logic             s1_move;
    logic             m_valid_reg;
    logic             m_ok_reg;
    logic [BYTE_W-1:0] m_char_reg;
    logic [CHAR_IDX_W-1:0] m_idx_reg;
    logic             m_last_reg;

    logic              in_accept;
    logic [BYTE_W-1:0] b;
    logic [2*CFG_W-1:0] name_bytes;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  nlen_ext;
    logic [BYTE_W-1:0] name_char;
    logic              is_sep;

    assign s_tready  = !(s_tlast && job_busy_reg);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign b         = s_tdata[BYTE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= NAME_LEN_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NAME_LOW:  name_low_reg  <= cfg_data;
                REG_NAME_HIGH: name_high_reg <= cfg_data;
                REG_NAME_LEN:  name_len_reg  <= cfg_data[NAME_LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // parse step: byte checks, then the segment machine, then the end-of-header checks
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        match_next  = match_reg;
        vc_next     = vc_reg;
        found_next  = found_reg;
        failed_next = failed_reg;
        hlen_next   = hlen_reg;
        success     = 1'b0;
        is_sep      = (b == CH_SPACE) || (b == CH_SEMI);
        name_bytes  = {name_high_reg, name_low_reg};
        pos_ext     = '0;
        nlen_ext    = CMP_W'(name_len_reg);
        name_char   = '0;

        if (hlen_reg < HL_W'(HEADER_MAX))
            hlen_next = hlen_reg + HL_W'(1);
        if (hlen_next >= HL_W'(HEADER_MAX) || b == CH_NUL)
            failed_next = 1'b1;

        if (!failed_next)
        begin
            if ((mode_reg == MODE_START || mode_reg == MODE_SKIP) && is_sep)
            begin
                mode_next = MODE_SKIP;
            end
            else
            begin
                if (mode_reg == MODE_START || mode_reg == MODE_SKIP)
                begin
                    mode_next  = MODE_NAME;
                    pos_next   = '0;
                    match_next = 1'b1;
                end
                pos_ext   = CMP_W'(pos_next);
                name_char = name_bytes[pos_ext[3:0]*BYTE_W +: BYTE_W];
                unique case (mode_next)
                    MODE_NAME:
                    begin
                        if (b == CH_EQ)
                        begin
                            match_next = match_next && (pos_ext == nlen_ext);
                            mode_next  = MODE_VALUE;
                            vc_next    = '0;
                        end
                        else if (b == CH_SEMI)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            if (!(pos_ext < nlen_ext && pos_next < NP_W'(NAME_MAX)
                                  && name_char == b))
                                match_next = 1'b0;
                            if (pos_next < NP_W'(NAME_MAX + 1))
                                pos_next = pos_next + NP_W'(1);
                        end
                    end
                    MODE_VALUE:
                    begin
                        if (b == CH_SEMI)
                        begin
                            if (match_next)
                            begin
                                if (found_next || vc_next != VC_W'(TOKEN_LEN))
                                    failed_next = 1'b1;
                                else
                                    found_next = 1'b1;
                            end
                            mode_next = MODE_START;
                        end
                        else if (vc_next < VC_W'(TOKEN_LEN + 1))
                        begin
                            vc_next = vc_next + VC_W'(1);
                        end
                    end
                    default: failed_next = 1'b1;
                endcase
            end
        end

        if (s_tlast)
        begin
            if (!failed_next)
            begin
                if (mode_next == MODE_VALUE)
                begin
                    if (match_next)
                    begin
                        if (found_next || vc_next != VC_W'(TOKEN_LEN))
                            failed_next = 1'b1;
                        else
                            found_next = 1'b1;
                    end
                end
                else if (mode_next != MODE_START)
                begin
                    failed_next = 1'b1;
                end
            end
            success     = !failed_next && found_next;
            mode_next   = MODE_START;
            pos_next    = '0;
            match_next  = 1'b1;
            vc_next     = '0;
            found_next  = 1'b0;
            failed_next = 1'b0;
            hlen_next   = '0;
        end
    end

    // token byte write: value byte of a matching segment while the token is not yet full
    always_comb
    begin
        wr_en   = in_accept && !failed_reg && (hlen_reg < HL_W'(HEADER_MAX - 1))
                  && b != CH_NUL && mode_reg == MODE_VALUE && b != CH_SEMI
                  && match_reg && vc_reg < VC_W'(TOKEN_LEN);
        wr_addr = bank_reg ? MA_W'(TOKEN_LEN) + MA_W'(vc_reg[IDX_W-1:0])
                           : MA_W'(vc_reg[IDX_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            pos_reg    <= '0;
            match_reg  <= 1'b1;
            vc_reg     <= '0;
            found_reg  <= 1'b0;
            failed_reg <= 1'b0;
            hlen_reg   <= '0;
            bank_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            vc_reg     <= vc_next;
            found_reg  <= found_next;
            failed_reg <= failed_next;
            hlen_reg   <= hlen_next;
            // after a successful header, the next header's token goes to the other bank
            if (s_tlast && success)
                bank_reg <= !bank_reg;
        end
    end

    // result job
    assign s1_move    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign issue      = job_busy_reg && (!s1_valid_reg || s1_move);
    assign issue_last = !job_ok_reg || (gen_idx_reg == IDX_W'(TOKEN_LEN - 1));
    assign rd_addr    = job_bank_reg ? MA_W'(TOKEN_LEN) + MA_W'(gen_idx_reg)
                                     : MA_W'(gen_idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            token_mem[wr_addr] <= b;
        if (issue && job_ok_reg)
            rd_data_reg <= token_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_busy_reg <= 1'b0;
            job_ok_reg   <= 1'b0;
            job_bank_reg <= 1'b0;
            gen_idx_reg  <= '0;
        end
        else if (in_accept && s_tlast)
        begin
            job_busy_reg <= 1'b1;
            job_ok_reg   <= success;
            job_bank_reg <= bank_reg;
            gen_idx_reg  <= '0;
        end
        else if (issue)
        begin
            gen_idx_reg <= gen_idx_reg + IDX_W'(1);
            if (issue_last)
                job_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (issue)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_ok_reg   <= job_ok_reg;
            s1_idx_reg  <= job_ok_reg ? gen_idx_reg : '0;
            s1_last_reg <= issue_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s1_move)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            m_ok_reg   <= s1_ok_reg;
            m_char_reg <= s1_ok_reg ? rd_data_reg : '0;
            m_idx_reg  <= CHAR_IDX_W'(s1_idx_reg);
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CHAR_IDX_W - BYTE_W){1'b0}}, m_idx_reg, m_char_reg};
    assign m_tuser  = m_ok_reg;
    assign m_tlast  = m_last_reg;

    // a marked byte always opens a result job
    a_last_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> job_busy_reg)
        else $error("marked byte did not start a result job");

    // a request held in the read stage is not dropped while the output stalls
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_valid_reg && !m_tready |=> s1_valid_reg)
        else $error("read stage lost a request under back-pressure");

    // a failure result is a single, final, zeroed result
    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
        else $error("failure result is malformed");

endmodule

`default_nettype wire

### bench/http_cookie_token_extractor_tb.sv
// http_cookie_token_extractor_tb: self-checking bench for the cookie header token extractor
// streams directed and random cookie headers, predicts every result in-bench and checks it
// depends on hcte_pkg and http_cookie_token_extractor
`default_nettype none

module http_cookie_token_extractor_tb;
    import hcte_pkg::*;

    localparam int unsigned TOKEN_LEN   = 32;
    localparam int unsigned HEADER_MAX  = 256;
    localparam int unsigned NAME_MAX    = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [BYTE_W-1:0] CH_FILLER = 8'h7e;

    typedef struct packed {
        logic                  ok;
        logic [BYTE_W-1:0]     token_char;
        logic [CHAR_IDX_W-1:0] char_index;
        logic                  last_result;
    } cookie_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] hdr_byte;
        logic              last;
        logic              want_reject;
    } header_row_t;

    localparam cookie_result_t REJECTED = '{1'b0, 8'h00, 6'd0, 1'b1};

    // directed headers under the reset name, none of which can yield a token
    localparam int unsigned N_ROWS = 17;
    localparam header_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'h78, 1'b1, 1'b1},                                          // no equals
        '{CH_NUL, 1'b1, 1'b1},                                         // zero byte
        '{CH_SEMI, 1'b1, 1'b1},                                        // only skipped
        '{CH_SPACE, 1'b0, 1'b0}, '{CH_SEMI, 1'b1, 1'b1},               // ends while skipping
        '{8'h61, 1'b0, 1'b0}, '{CH_EQ, 1'b0, 1'b0}, '{8'h62, 1'b0, 1'b0},
        '{CH_SEMI, 1'b1, 1'b1},                                        // ends after semicolon
        '{8'hff, 1'b0, 1'b0}, '{CH_EQ, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b1},
        '{8'h61, 1'b0, 1'b0}, '{CH_SEMI, 1'b0, 1'b0}, '{8'h62, 1'b0, 1'b0},
        '{CH_EQ, 1'b1, 1'b1},                                          // semicolon in a name
        '{CH_EQ, 1'b1, 1'b1}                                           // empty name
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    http_cookie_token_extractor #(
        .TOKEN_LEN  (TOKEN_LEN),
        .HEADER_MAX (HEADER_MAX),
        .NAME_MAX   (NAME_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // bench copy of the registers and of the per-header parse state
    logic [CFG_W-1:0]      name_word_lo = '0;
    logic [CFG_W-1:0]      name_word_hi = '0;
    logic [NAME_LEN_W-1:0] name_len = 5'd1;
    parse_mode_t           mode = MODE_START;
    int unsigned           name_pos = 0;
    bit                    name_hit = 1'b1;
    int unsigned           value_len = 0;
    bit                    token_seen = 1'b0;
    bit                    header_bad = 1'b0;
    int unsigned           header_len = 0;
    logic [BYTE_W-1:0]     token_bytes [TOKEN_LEN];

    cookie_result_t        header_results [$];
    cookie_result_t        results_due [$];
    cookie_result_t        got;
    cookie_result_t        want;
    logic [BYTE_W-1:0]     hdr [$];
    int unsigned           errors = 0;
    int unsigned           cycle_count = 0;
    int unsigned           src_idle_pct = 20;
    int unsigned           sink_idle_pct = 66;
    int unsigned           hold_left = 0;

    function automatic void clear_header_state();
        mode = MODE_START;
        name_pos = 0;
        name_hit = 1'b1;
        value_len = 0;
        token_seen = 1'b0;
        header_bad = 1'b0;
        header_len = 0;
    endfunction

    function automatic logic [BYTE_W-1:0] name_char(int unsigned pos);
        int unsigned p;
        p = pos & 15;
        return (p < 8) ? name_word_lo[8*p +: 8] : name_word_hi[8*(p-8) +: 8];
    endfunction

    function automatic void finish_segment();
        if (name_hit) begin
            if (token_seen || value_len != TOKEN_LEN)
                header_bad = 1'b1;
            else
                token_seen = 1'b1;
        end
    endfunction

    function automatic void consume_byte(logic [BYTE_W-1:0] b);
        if (mode == MODE_START || mode == MODE_SKIP) begin
            if (b == CH_SPACE || b == CH_SEMI) begin
                mode = MODE_SKIP;
                return;
            end
            mode = MODE_NAME;
            name_pos = 0;
            name_hit = 1'b1;
        end
        if (mode == MODE_NAME) begin
            if (b == CH_EQ) begin
                name_hit = name_hit && (name_pos == name_len);
                mode = MODE_VALUE;
                value_len = 0;
            end
            else if (b == CH_SEMI)
                header_bad = 1'b1;
            else begin
                if (!(name_pos < name_len && name_pos < NAME_MAX && name_char(name_pos) == b))
                    name_hit = 1'b0;
                if (name_pos < NAME_MAX + 1)
                    name_pos++;
            end
            return;
        end
        if (b == CH_SEMI) begin
            finish_segment();
            mode = MODE_START;
            return;
        end
        if (name_hit && value_len < TOKEN_LEN)
            token_bytes[value_len] = b;
        if (value_len < TOKEN_LEN + 1)
            value_len++;
    endfunction

    // advances the parse by one byte; on the marked byte fills header_results
    function automatic void predict_header_byte(logic [BYTE_W-1:0] b, logic last);
        header_results.delete();
        if (header_len < HEADER_MAX)
            header_len++;
        if (header_len >= HEADER_MAX || b == CH_NUL)
            header_bad = 1'b1;
        if (!header_bad)
            consume_byte(b);
        if (!last)
            return;
        if (!header_bad) begin
            if (mode == MODE_VALUE)
                finish_segment();
            else if (mode != MODE_START)
                header_bad = 1'b1;
        end
        if (!header_bad && token_seen) begin
            for (int k = 0; k < TOKEN_LEN; k++)
                header_results.push_back('{1'b1, token_bytes[k], 6'(k), k == TOKEN_LEN - 1});
        end
        else
            header_results.push_back(REJECTED);
        clear_header_state();
    endfunction

    function automatic void report_mismatch(string field, int unsigned exp, int unsigned act);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp, act);
        errors++;
    endfunction

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("http_cookie_token_extractor_tb: FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold when asked
    always @(posedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[7:0], m_tdata[13:8], m_tlast};
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
            end
            else begin
                want = results_due.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", want.ok, got.ok);
                if (got.token_char !== want.token_char)
                    report_mismatch("token_char", want.token_char, got.token_char);
                if (got.char_index !== want.char_index)
                    report_mismatch("char_index", want.char_index, got.char_index);
                if (got.last_result !== want.last_result)
                    report_mismatch("last_result", want.last_result, got.last_result);
            end
        end
    end

    // valid stays high from one request to the next unless the sender idles
    task automatic send_header_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    input logic typed_reject);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        predict_header_byte(b, last);
        if (typed_reject)
            results_due.push_back(REJECTED);
        else
            foreach (header_results[i])
                results_due.push_back(header_results[i]);
    endtask

    task automatic send_header();
        foreach (hdr[i])
            send_header_byte(hdr[i], i == hdr.size() - 1, 1'b0);
    endtask

    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_NAME_LOW:  name_word_lo = val;
            REG_NAME_HIGH: name_word_hi = val;
            REG_NAME_LEN:  name_len = val[NAME_LEN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [BYTE_W-1:0] plain_char();
        logic [BYTE_W-1:0] b;
        do b = $urandom_range(255, 1); while (b == CH_SPACE || b == CH_SEMI || b == CH_EQ);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] value_char();
        logic [BYTE_W-1:0] b;
        do b = $urandom_range(255, 1); while (b == CH_SEMI);
        return b;
    endfunction

    function automatic logic [CFG_W-1:0] plain_word();
        logic [CFG_W-1:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = plain_char();
        return w;
    endfunction

    function automatic void add_segment(bit target, int unsigned vlen, bit drop_eq);
        if (target) begin
            for (int i = 0; i < name_len && i < NAME_MAX; i++)
                hdr.push_back(name_char(i));
            if (name_len > NAME_MAX)
                hdr.push_back(plain_char());
        end
        else
            repeat ($urandom_range(6, 1)) hdr.push_back(plain_char());
        if (!drop_eq)
            hdr.push_back(CH_EQ);
        repeat (vlen) hdr.push_back(value_char());
    endfunction

    // flaw: 0 none, 1 token size, 2 second token, 3 no equals, 4 zero byte, 5 trailing skip
    function automatic void build_cookie_header(int unsigned flaw, int unsigned pad_to);
        int unsigned n_seg;
        int unsigned tgt;
        int unsigned bad_len;
        n_seg = $urandom_range(4, 1);
        tgt = $urandom_range(n_seg - 1, 0);
        hdr.delete();
        if (flaw == 3 && $urandom_range(1)) begin
            add_segment(1'b0, 0, 1'b1);
            hdr.push_back(CH_SEMI);
        end
        for (int s = 0; s < n_seg; s++) begin
            if (s > 0)
                hdr.push_back(CH_SEMI);
            repeat ($urandom_range(2, 0)) hdr.push_back($urandom_range(1) ? CH_SPACE : CH_SEMI);
            if (s != tgt)
                add_segment(1'b0, $urandom_range(8, 0), 1'b0);
            else if (flaw == 1) begin
                case ($urandom_range(3))
                    0: bad_len = 0;
                    1: bad_len = TOKEN_LEN - 1;
                    2: bad_len = TOKEN_LEN + 1;
                    default: bad_len = $urandom_range(TOKEN_LEN - 1, 1);
                endcase
                add_segment(1'b1, bad_len, 1'b0);
            end
            else
                add_segment(1'b1, TOKEN_LEN, 1'b0);
        end
        if (pad_to > hdr.size() + 3) begin
            hdr.push_back(CH_SEMI);
            hdr.push_back(CH_FILLER);
            hdr.push_back(CH_EQ);
            while (hdr.size() < pad_to) hdr.push_back(value_char());
        end
        case (flaw)
            2: begin
                hdr.push_back(CH_SEMI);
                add_segment(1'b1, TOKEN_LEN, 1'b0);
            end
            3: if (hdr[0] != CH_SEMI && $urandom_range(1)) begin
                hdr.push_back(CH_SEMI);
                add_segment(1'b0, 0, 1'b1);
            end
            4: hdr.insert($urandom_range(hdr.size() - 1, 0), CH_NUL);
            5: begin
                hdr.push_back(CH_SEMI);
                hdr.push_back(CH_SPACE);
            end
            default: if (flaw == 0 && pad_to == 0 && $urandom_range(2) == 0)
                hdr.push_back(CH_SEMI);
        endcase
    endfunction

    function automatic void build_noise_header();
        hdr.delete();
        repeat ($urandom_range(12, 1)) begin
            case ($urandom_range(9))
                0: hdr.push_back(CH_SPACE);
                1: hdr.push_back(CH_SEMI);
                2: hdr.push_back(CH_EQ);
                3: hdr.push_back(CH_NUL);
                default: hdr.push_back($urandom_range(255));
            endcase
        end
    endfunction

    task automatic run_phase(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [CFG_W-1:0] len_word, input int unsigned src_pct,
                             input int unsigned sink_pct, input bit long_headers,
                             input bit hold);
        int unsigned sent;
        int unsigned headers;
        int unsigned pick;
        sent = 0;
        headers = 0;
        drain_stream();
        write_register(REG_NAME_LOW, lo);
        write_register(REG_NAME_HIGH, hi);
        write_register(REG_SPARE, {$urandom, $urandom});
        write_register(REG_NAME_LEN, len_word);
        cfg_valid <= 1'b0;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        if (hold)
            hold_left <= HOLD_CYCLES;
        if (long_headers) begin
            // just under and just at the length limit
            build_cookie_header(0, HEADER_MAX - 1);
            send_header();
            build_cookie_header(0, HEADER_MAX);
            send_header();
        end
        while (sent < 80 || headers < 3) begin
            pick = $urandom_range(99);
            if (pick < 60)
                build_cookie_header(0, 0);
            else if (pick < 88)
                build_cookie_header($urandom_range(5, 1), 0);
            else
                build_noise_header();
            send_header();
            sent += hdr.size();
            headers++;
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
            send_header_byte(DIRECTED_ROWS[r].hdr_byte, DIRECTED_ROWS[r].last,
                             DIRECTED_ROWS[r].want_reject);

        run_phase(plain_word(), plain_word(), 64'd1, 20, 66, 1'b0, 1'b0);
        run_phase(plain_word(), plain_word(), 64'd16, 20, 66, 1'b1, 1'b0);
        // empty name, with the receiver held off so that requests back up
        run_phase(plain_word(), plain_word(), 64'd0, 66, 20, 1'b0, 1'b1);
        run_phase({CFG_W{1'b1}}, '0, 64'd17, 66, 20, 1'b0, 1'b0);
        run_phase(plain_word(), plain_word(), 64'($urandom_range(15, 2)), 0, 0, 1'b0, 1'b0);
        // upper bits of the length word are dropped, leaving one character
        run_phase(plain_word(), plain_word(), 64'hffff_ffff_ffff_ffe1, 0, 0, 1'b0, 1'b0);

        drain_stream();
        repeat (32) @(posedge clk);
        if (errors == 0)
            $display("http_cookie_token_extractor_tb: PASS");
        else
            $display("http_cookie_token_extractor_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
